### rtl/quaternary_periodic_autocorrelation_core_defines.svh
// ----------------------------------------------------------------------------
// Quaternary periodic autocorrelation core - assertion macros
// Shared assertion helpers for the modules of the correlation core.
// ----------------------------------------------------------------------------
`ifndef QUATERNARY_PERIODIC_AUTOCORRELATION_CORE_DEFINES_SVH
`define QUATERNARY_PERIODIC_AUTOCORRELATION_CORE_DEFINES_SVH

// General form: explicit clock and active-low reset.
`define QPAC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Short form for the core's own clock and reset names.
`define QPAC_ASSERT(lbl, prop, msg) \
    `QPAC_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

### rtl/qpac_pkg.sv
// ----------------------------------------------------------------------------
// qpac_pkg
// Constants, types and helper functions shared by the correlation core.
// ----------------------------------------------------------------------------
`default_nettype none

package qpac_pkg;

    localparam int SEQ_LENGTH = 21;
    localparam int NUM_LAGS   = 10;

    localparam int LAG_W      = 4;
    localparam int CORR_W     = 6;
    localparam int LAG_CNT_W  = $clog2(NUM_LAGS + 1);
    localparam int SHIFT_W    = $clog2(SEQ_LENGTH);
    localparam int CNT_W      = $clog2(SEQ_LENGTH + 1);

    typedef logic [SEQ_LENGTH-1:0] seq_vec_t;

    // One sequence as it travels from the front end to the back end.
    // hole marks the elements that are forced to zero.
    typedef struct packed {
        seq_vec_t axis;
        seq_vec_t sign;
        seq_vec_t hole;
    } qpac_item_t;

    // Population counts for one lag.
    typedef struct packed {
        logic [CNT_W-1:0] same;
        logic [CNT_W-1:0] same_flip;
        logic [CNT_W-1:0] to_real;
        logic [CNT_W-1:0] to_real_flip;
        logic [CNT_W-1:0] to_imag;
        logic [CNT_W-1:0] to_imag_flip;
    } qpac_counts_t;

    // Bit j of the result is bit (j + s) mod SEQ_LENGTH of v, for s below SEQ_LENGTH.
    function automatic seq_vec_t rot_down(input seq_vec_t v, input logic [SHIFT_W-1:0] s);
        logic [2*SEQ_LENGTH-1:0] dbl;
        dbl = {v, v} >> s;
        return dbl[SEQ_LENGTH-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] pop_count(input seq_vec_t v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < SEQ_LENGTH; i++) begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/quaternary_periodic_autocorrelation_core.sv
// ----------------------------------------------------------------------------
// Quaternary periodic autocorrelation core
// Periodic autocorrelation of a length-21 sequence of Gaussian units.
// ----------------------------------------------------------------------------
// Usage. The input channel (s_valid/s_ready) carries one sequence per
// transaction: s_axis_mask marks elements on the imaginary axis, s_sign_mask
// marks negative elements and s_zero_first forces element zero to zero.
// The result channel (m_valid/m_ready) returns ten transactions per sequence,
// one for each lag from 1 to 10 in increasing order, with the real and
// imaginary parts of the correlation and m_last set on lag 10.
// A sequence passes the input register, the queue, the sequencer, the count
// stage and the output register; its results follow one per cycle while
// m_ready stays high. The single correlation lane in the back end takes the
// next sequence as it issues the last lag of the current one.
// Reset (aresetn low at a clock edge) empties the input register, the queue
// and the result pipeline; any sequence in flight is dropped.
// When the receiver holds m_ready low, the current result stays on the
// outputs, the pipeline and the two-entry queue fill, and s_ready falls only
// once the input register has nowhere to go.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternary_periodic_autocorrelation_core (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [qpac_pkg::SEQ_LENGTH-1:0]       s_axis_mask,
    input  wire logic [qpac_pkg::SEQ_LENGTH-1:0]       s_sign_mask,
    input  wire logic                                  s_zero_first,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [qpac_pkg::LAG_W-1:0]                 m_lag,
    output logic signed [qpac_pkg::CORR_W-1:0]         m_corr_real,
    output logic signed [qpac_pkg::CORR_W-1:0]         m_corr_imag,
    output logic                                       m_last
);
    import qpac_pkg::*;

    // Front end to queue.
    logic       fe_valid;
    logic       fe_ready;
    qpac_item_t fe_item;

    // Queue to back end.
    logic       q_valid;
    logic       q_ready;
    qpac_item_t q_item;

    // The front end registers each transaction and builds the mask of
    // zeroed elements, so the back end only deals with bit vectors.
    qpac_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_axis_mask  (s_axis_mask),
        .s_sign_mask  (s_sign_mask),
        .s_zero_first (s_zero_first),
        .item_valid   (fe_valid),
        .item_ready   (fe_ready),
        .item         (fe_item)
    );

    // The queue lets the front end keep taking sequences while the back
    // end is still stepping through the lags of an earlier one.
    qpac_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_item  (fe_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // The back end rotates the masks by one more place each cycle that it is
    // not stalled, counts the matching pairs into a register stage and forms
    // the two correlation parts as they load the output register.
    qpac_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (q_valid),
        .item_ready  (q_ready),
        .item        (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_lag       (m_lag),
        .m_corr_real (m_corr_real),
        .m_corr_imag (m_corr_imag),
        .m_last      (m_last)
    );

endmodule

`default_nettype wire

### rtl/qpac_front.sv
// ----------------------------------------------------------------------------
// qpac_front
// Input stage: takes a transaction and turns the zero flag into a hole mask.
// ----------------------------------------------------------------------------
`default_nettype none

module qpac_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [qpac_pkg::SEQ_LENGTH-1:0]   s_axis_mask,
    input  wire logic [qpac_pkg::SEQ_LENGTH-1:0]   s_sign_mask,
    input  wire logic                              s_zero_first,
    output logic                                   item_valid,
    input  wire logic                              item_ready,
    output qpac_pkg::qpac_item_t                   item
);
    import qpac_pkg::*;

    logic       valid_reg;
    qpac_item_t item_reg;

    assign s_ready    = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.axis <= s_axis_mask;
            item_reg.sign <= s_sign_mask;
            item_reg.hole <= s_zero_first ? seq_vec_t'(1) : '0;
        end
    end

endmodule

`default_nettype wire

### rtl/qpac_fifo.sv
// ----------------------------------------------------------------------------
// qpac_fifo
// Two-entry queue between the front end and the correlation back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternary_periodic_autocorrelation_core_defines.svh"

module qpac_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire qpac_pkg::qpac_item_t  push_item,
    output logic                       pop_valid,
    input  wire logic                  pop_ready,
    output qpac_pkg::qpac_item_t       pop_item
);
    import qpac_pkg::*;

    logic       head_valid_reg;
    logic       tail_valid_reg;
    qpac_item_t head_reg;
    qpac_item_t tail_reg;
    logic       push;
    logic       pop;

    assign push_ready = !tail_valid_reg;
    assign pop_valid  = head_valid_reg;
    assign pop_item   = head_reg;
    assign push       = push_valid && push_ready;
    assign pop        = head_valid_reg && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end else if (pop) begin
            if (tail_valid_reg) begin
                tail_valid_reg <= 1'b0;
            end else begin
                head_valid_reg <= push;
            end
        end else if (push) begin
            if (head_valid_reg) begin
                tail_valid_reg <= 1'b1;
            end else begin
                head_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && tail_valid_reg) begin
            head_reg <= tail_reg;
        end else if (push && (pop || !head_valid_reg)) begin
            head_reg <= push_item;
        end
        if (push && head_valid_reg && !pop) begin
            tail_reg <= push_item;
        end
    end

    `QPAC_ASSERT(a_tail_needs_head, tail_valid_reg |-> head_valid_reg, "queue tail without head")
    `QPAC_ASSERT(a_fill_second, (push && !pop && head_valid_reg) |=> tail_valid_reg, "second entry lost")
    `QPAC_ASSERT(a_drain_last, (pop && !push && !tail_valid_reg) |=> !head_valid_reg, "queue not emptied")

endmodule

`default_nettype wire

### rtl/qpac_back.sv
// ----------------------------------------------------------------------------
// qpac_back
// Correlation engine: one lag of one sequence per cycle while the output flows.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternary_periodic_autocorrelation_core_defines.svh"

module qpac_back (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  item_valid,
    output logic                                       item_ready,
    input  wire qpac_pkg::qpac_item_t                  item,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [qpac_pkg::LAG_W-1:0]                 m_lag,
    output logic signed [qpac_pkg::CORR_W-1:0]         m_corr_real,
    output logic signed [qpac_pkg::CORR_W-1:0]         m_corr_imag,
    output logic                                       m_last
);
    import qpac_pkg::*;

    // Sequencer state.
    logic                 busy_reg;
    qpac_item_t           cur_reg;
    logic [LAG_CNT_W-1:0] lag_reg;
    logic [SHIFT_W-1:0]   shift_reg;

    // Count stage.
    logic                 s1_valid_reg;
    qpac_counts_t         s1_counts_reg;
    logic [LAG_CNT_W-1:0] s1_lag_reg;
    logic                 s1_last_reg;

    // Output stage.
    logic                 m_valid_reg;
    logic [LAG_W-1:0]     m_lag_reg;
    logic [CORR_W-1:0]    m_real_reg;
    logic [CORR_W-1:0]    m_imag_reg;
    logic                 m_last_reg;

    logic         out_load;
    logic         s1_load;
    logic         issue;
    logic         lag_is_last;
    logic         take;
    seq_vec_t     nxt_axis;
    seq_vec_t     nxt_sign;
    seq_vec_t     nxt_hole;
    seq_vec_t     pair_ok;
    seq_vec_t     flip;
    seq_vec_t     same;
    seq_vec_t     to_real;
    seq_vec_t     to_imag;
    qpac_counts_t counts;

    assign out_load    = !m_valid_reg || m_ready;
    assign s1_load     = !s1_valid_reg || out_load;
    assign issue       = busy_reg && s1_load;
    assign lag_is_last = (lag_reg == LAG_CNT_W'(NUM_LAGS));
    assign item_ready  = !busy_reg || (issue && lag_is_last);
    assign take        = item_valid && item_ready;

    always_comb begin
        nxt_axis = rot_down(cur_reg.axis, shift_reg);
        nxt_sign = rot_down(cur_reg.sign, shift_reg);
        nxt_hole = rot_down(cur_reg.hole, shift_reg);
        pair_ok  = ~(cur_reg.hole | nxt_hole);
        flip     = cur_reg.sign ^ nxt_sign;
        same     = pair_ok & ~(cur_reg.axis ^ nxt_axis);
        to_real  = pair_ok & cur_reg.axis & ~nxt_axis;
        to_imag  = pair_ok & ~cur_reg.axis & nxt_axis;

        counts.same         = pop_count(same);
        counts.same_flip    = pop_count(same & flip);
        counts.to_real      = pop_count(to_real);
        counts.to_real_flip = pop_count(to_real & flip);
        counts.to_imag      = pop_count(to_imag);
        counts.to_imag_flip = pop_count(to_imag & flip);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (take) begin
            busy_reg <= 1'b1;
        end else if (issue && lag_is_last) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cur_reg   <= item;
            lag_reg   <= LAG_CNT_W'(1);
            shift_reg <= SHIFT_W'(1);
        end else if (issue && !lag_is_last) begin
            lag_reg   <= lag_reg + LAG_CNT_W'(1);
            shift_reg <= (shift_reg == SHIFT_W'(SEQ_LENGTH - 1)) ? '0
                                                                : shift_reg + SHIFT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_load) begin
                s1_valid_reg <= issue;
            end
            if (out_load) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_counts_reg <= counts;
            s1_lag_reg    <= lag_reg;
            s1_last_reg   <= lag_is_last;
        end
        if (out_load && s1_valid_reg) begin
            m_lag_reg  <= LAG_W'(s1_lag_reg);
            m_last_reg <= s1_last_reg;
            m_real_reg <= CORR_W'(s1_counts_reg.same)
                        - (CORR_W'(s1_counts_reg.same_flip) << 1);
            m_imag_reg <= CORR_W'(s1_counts_reg.to_real)
                        - (CORR_W'(s1_counts_reg.to_real_flip) << 1)
                        - CORR_W'(s1_counts_reg.to_imag)
                        + (CORR_W'(s1_counts_reg.to_imag_flip) << 1);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_lag       = m_lag_reg;
    assign m_corr_real = m_real_reg;
    assign m_corr_imag = m_imag_reg;
    assign m_last      = m_last_reg;

    `QPAC_ASSERT(a_lag_range, busy_reg |-> (lag_reg != '0 && lag_reg <= LAG_CNT_W'(NUM_LAGS)), "lag out of range")
    `QPAC_ASSERT(a_last_lag, (s1_valid_reg && s1_last_reg) |-> (s1_lag_reg == LAG_CNT_W'(NUM_LAGS)), "last flag on wrong lag")
    `QPAC_ASSERT(a_lag_step, (issue && !lag_is_last && !take) |=> (busy_reg && lag_reg == $past(lag_reg) + LAG_CNT_W'(1)), "lag did not advance")

endmodule

`default_nettype wire

### test/qpac_correlation_checker.sv
// ----------------------------------------------------------------------------
// Periodic autocorrelation checker
// Watches both channels of the correlation core. It computes the ten lag
// values of every accepted sequence and checks each returned result against
// the oldest value still outstanding.
// ----------------------------------------------------------------------------
module qpac_correlation_checker
    import qpac_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    input  wire logic                     s_ready,
    input  wire logic [SEQ_LENGTH-1:0]    s_axis_mask,
    input  wire logic [SEQ_LENGTH-1:0]    s_sign_mask,
    input  wire logic                     s_zero_first,
    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  wire logic [LAG_W-1:0]         m_lag,
    input  wire logic signed [CORR_W-1:0] m_corr_real,
    input  wire logic signed [CORR_W-1:0] m_corr_imag,
    input  wire logic                     m_last,
    output int                            mismatch_count,
    output int                            pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [LAG_W-1:0]         lag;
        logic signed [CORR_W-1:0] re;
        logic signed [CORR_W-1:0] im;
        logic                     last;
    } corr_point_t;

    corr_point_t awaited_corr[$];
    int          mismatches  = 0;
    int          outstanding = 0;

    assign mismatch_count  = mismatches;
    assign pending_results = outstanding;

    task automatic flag_mismatch(input string what);
        $display("[%0t ns] correlation mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Bit j of the result is bit (j + s) mod SEQ_LENGTH of v.
    function automatic seq_vec_t cyclic_advance(input seq_vec_t v, input int s);
        seq_vec_t r;
        for (int j = 0; j < SEQ_LENGTH; j++) begin
            r[j] = v[(j + s) % SEQ_LENGTH];
        end
        return r;
    endfunction

    task automatic queue_correlations(input seq_vec_t axis, input seq_vec_t sign,
                                      input logic zero_first);
        seq_vec_t    moved_axis;
        seq_vec_t    moved_sign;
        seq_vec_t    live;
        seq_vec_t    flip;
        seq_vec_t    same;
        seq_vec_t    to_real;
        seq_vec_t    to_imag;
        int          shift;
        int          re;
        int          im;
        corr_point_t pt;
        for (int lag = 1; lag <= NUM_LAGS; lag++) begin
            shift      = lag % SEQ_LENGTH;
            moved_axis = cyclic_advance(axis, shift);
            moved_sign = cyclic_advance(sign, shift);
            live       = '1;
            // A zeroed first element kills its own product and the one that pairs with it.
            if (zero_first) begin
                live[0] = 1'b0;
                live[(SEQ_LENGTH - shift) % SEQ_LENGTH] = 1'b0;
            end
            flip    = sign ^ moved_sign;
            same    = live & ~(axis ^ moved_axis);
            to_real = live & axis & ~moved_axis;
            to_imag = live & ~axis & moved_axis;
            re = $countones(same) - 2 * $countones(same & flip);
            im = $countones(to_real) - 2 * $countones(to_real & flip)
               - $countones(to_imag) + 2 * $countones(to_imag & flip);
            pt.lag  = LAG_W'(lag);
            pt.re   = CORR_W'(re);
            pt.im   = CORR_W'(im);
            pt.last = (lag == NUM_LAGS);
            awaited_corr.insert(awaited_corr.size(), pt);
        end
    endtask

    always @(posedge aclk) begin : watch
        corr_point_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                queue_correlations(s_axis_mask, s_sign_mask, s_zero_first);
            end
            if (m_valid === 1'b1 && m_ready) begin
                if (awaited_corr.size() == 0) begin
                    flag_mismatch($sformatf("result for lag %0d with nothing outstanding",
                                            m_lag));
                end else begin
                    want = awaited_corr.pop_front();
                    if (m_lag !== want.lag)
                        flag_mismatch($sformatf("lag %0d, expected %0d", m_lag, want.lag));
                    if (m_corr_real !== want.re)
                        flag_mismatch($sformatf("lag %0d real part %0d, expected %0d",
                                                want.lag, m_corr_real, want.re));
                    if (m_corr_imag !== want.im)
                        flag_mismatch($sformatf("lag %0d imaginary part %0d, expected %0d",
                                                want.lag, m_corr_imag, want.im));
                    if (m_last !== want.last)
                        flag_mismatch($sformatf("lag %0d last flag %0b, expected %0b",
                                                want.lag, m_last, want.last));
                end
            end
        end
        outstanding = awaited_corr.size();
    end

endmodule

### test/quaternary_periodic_autocorrelation_core_tb.sv
// ----------------------------------------------------------------------------
// Quaternary periodic autocorrelation core testbench
// Drives sequences into the core, first a directed set and then random ones
// under several idling profiles, while a checker beside the core predicts
// and compares every result transaction.
// ----------------------------------------------------------------------------
module quaternary_periodic_autocorrelation_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qpac_pkg::*;

    // The clock toggles every nanosecond, giving a 2 ns period.
    localparam int CLK_HALF_NS     = 1;
    localparam int RESET_CYCLES    = 4;
    // Random sequences per idling phase; four phases give roughly 270.
    localparam int ITEMS_PER_PHASE = 68;
    localparam int NUM_PHASES      = 4;
    // The first result of a sequence is followed by nine more, so this
    // comfortably covers anything still on its way.
    localparam int SETTLE_CYCLES   = 40;
    // Far beyond the slowest correct run, even with every result stalled.
    localparam int RUN_LIMIT_NS    = 400_000;

    logic                     aclk         = 1'b0;
    logic                     aresetn      = 1'b0;
    logic                     s_valid      = 1'b0;
    logic                     s_ready;
    logic [SEQ_LENGTH-1:0]    s_axis_mask  = '0;
    logic [SEQ_LENGTH-1:0]    s_sign_mask  = '0;
    logic                     s_zero_first = 1'b0;
    logic                     m_valid;
    logic                     m_ready      = 1'b0;
    logic [LAG_W-1:0]         m_lag;
    logic signed [CORR_W-1:0] m_corr_real;
    logic signed [CORR_W-1:0] m_corr_imag;
    logic                     m_last;

    int mismatch_count;
    int pending_results;

    // Idling percentages, changed from one phase to the next. The phases
    // run: no idling, an idle sender, a stalling receiver, then both.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int send_idle_by_phase[NUM_PHASES]  = '{0, 60, 0, 18};
    int recv_stall_by_phase[NUM_PHASES] = '{0, 0, 60, 18};

    always #(CLK_HALF_NS) aclk = ~aclk;

    quaternary_periodic_autocorrelation_core u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_axis_mask  (s_axis_mask),
        .s_sign_mask  (s_sign_mask),
        .s_zero_first (s_zero_first),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_lag        (m_lag),
        .m_corr_real  (m_corr_real),
        .m_corr_imag  (m_corr_imag),
        .m_last       (m_last)
    );

    qpac_correlation_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_axis_mask     (s_axis_mask),
        .s_sign_mask     (s_sign_mask),
        .s_zero_first    (s_zero_first),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lag           (m_lag),
        .m_corr_real     (m_corr_real),
        .m_corr_imag     (m_corr_imag),
        .m_last          (m_last),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // The receiver makes a fresh decision on every falling edge, so that its
    // stalls land on every result of a sequence, not just the first.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one sequence and returns once the core has taken the
    // transaction. Before offering it, the sender may sit idle for a random
    // number of cycles, with rubbish on the payload to show that the core
    // only looks at it while valid is high.
    task automatic push_sequence(input seq_vec_t axis, input seq_vec_t sign,
                                 input logic zero_first);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid      <= 1'b0;
            s_axis_mask  <= SEQ_LENGTH'($urandom);
            s_sign_mask  <= SEQ_LENGTH'($urandom);
            s_zero_first <= 1'($urandom);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_axis_mask  <= axis;
        s_sign_mask  <= sign;
        s_zero_first <= zero_first;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    // Holds the sender back until the core has returned every result it
    // owes, so that the next sequence meets a completely empty pipeline.
    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
    endtask

    // Draws one mask: mostly uniform, sometimes sparse or dense, so that
    // nearly all-equal sequences turn up among the random ones too.
    function automatic seq_vec_t draw_mask();
        case ($urandom_range(3))
            2:       return SEQ_LENGTH'($urandom & $urandom & $urandom);
            3:       return SEQ_LENGTH'($urandom | $urandom | $urandom);
            default: return SEQ_LENGTH'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        // Reset is held low from the start and released on a falling edge.
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed sequences, sent back to back with the receiver always
        // ready. Sequences made of a single value give the peak real sum at
        // every lag, on either axis and with either sign, with and without a
        // zeroed first element.
        push_sequence('0, '0, 1'b0);
        push_sequence('0, '0, 1'b1);
        push_sequence('1, '0, 1'b0);
        push_sequence('1, '1, 1'b1);
        push_sequence('0, '1, 1'b0);
        push_sequence('1, '1, 1'b0);
        // Alternating axes bring in large imaginary parts, and alternating
        // signs drive the real part towards its negative end.
        push_sequence(21'h155555, 21'h000000, 1'b0);
        push_sequence(21'h0AAAAA, 21'h155555, 1'b1);
        push_sequence(21'h000000, 21'h155555, 1'b0);
        push_sequence(21'h0AAAAA, 21'h0AAAAA, 1'b0);
        // A lone odd element at either end of the masks, where the cyclic
        // wrap joins the last element to the first.
        push_sequence(21'h000001, 21'h100000, 1'b0);
        push_sequence(21'h100000, 21'h000001, 1'b1);
        push_sequence(21'h000001, 21'h000001, 1'b1);
        push_sequence(21'h100000, 21'h100000, 1'b0);
        // Blocks of one axis or sign against the other half of the sequence.
        push_sequence(21'h1FFC00, 21'h0003FF, 1'b0);
        push_sequence(21'h0003FF, 21'h1FFC00, 1'b1);
        push_sequence(21'h1C71C7, 21'h0E38E3, 1'b0);
        push_sequence(21'h123456, 21'h0FEDCB, 1'b1);

        // Let everything come back before the random part starts.
        hold_until_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            send_idle_pct  = send_idle_by_phase[phase];
            recv_stall_pct = recv_stall_by_phase[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Now and then the pipeline is allowed to run dry.
                if ($urandom_range(39) == 0) begin
                    hold_until_drained();
                end
                push_sequence(draw_mask(), draw_mask(), 1'($urandom));
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && pending_results == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // A hung handshake or results that never arrive end the run here.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### quaternary_periodic_autocorrelation_core.f
+incdir+rtl
rtl/qpac_pkg.sv
rtl/qpac_front.sv
rtl/qpac_fifo.sv
rtl/qpac_back.sv
rtl/quaternary_periodic_autocorrelation_core.sv
test/qpac_correlation_checker.sv
test/quaternary_periodic_autocorrelation_core_tb.sv
